// File: rtl/md5_pkg.sv
// MD5 digest unit: shared constants, round tables and channel payload types.
// No dependencies.
`default_nettype none
package md5_pkg;
  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       byte_valid;
    logic       last_byte;
  } md5_in_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic        part_index;
    logic        last_part;
  } md5_out_t;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] round_s(input logic [3:0] idx);
    logic [4:0] s;
    case (idx)
      4'd0: s = 5'd7;  4'd1: s = 5'd12; 4'd2: s = 5'd17; 4'd3: s = 5'd22;
      4'd4: s = 5'd5;  4'd5: s = 5'd9;  4'd6: s = 5'd14; 4'd7: s = 5'd20;
      4'd8: s = 5'd4;  4'd9: s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6; 4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

  function automatic logic [31:0] bswap(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction
endpackage
`default_nettype wire

// File: rtl/md5_stream_if.sv
// Valid/ready channel interface carrying one payload type.
// Depends on nothing; payload type is given by the parameter.
`default_nettype none
interface md5_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/md5_message_digest_unit.sv
// MD5 digest unit top level: byte buffer, padding sequencer, shared round unit.
// Depends on md5_pkg and md5_stream_if.
//
//  channel  dir  payload                                 transfer when
//  in_      in   msg_byte, byte_valid, last_byte          valid && ready
//  out_     out  digest_word, part_index, last_part       valid && ready
//
// A 64th byte starts the compression: the rounds run through the single round
// adder chain, then the chaining add. A closing item writes the padding byte
// by byte and runs one or two compressions, then offers two result words,
// each held until taken.
// Reset (rst_n low, synchronous) loads the initial chaining words.
// in_ready is low while busy.
`default_nettype none
module md5_message_digest_unit
  import md5_pkg::*;
(
  input  wire    clk,
  input  wire    rst_n,
  md5_stream_if.sink   in_ch,
  md5_stream_if.source out_ch
);
  localparam logic [2:0] ST_IDLE = 3'd0, ST_PAD = 3'd1, ST_ROUND = 3'd2,
                         ST_ADD = 3'd3, ST_OUT0 = 3'd4, ST_OUT1 = 3'd5;

  logic [2:0]  state_r, state_nxt;
  logic [31:0] store_r [16];          // block held as little-endian words
  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] bits_r, bits_nxt;
  logic [31:0] h_r [4];
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [5:0]  rnd_r, rnd_nxt;
  logic        final_r, final_nxt;  // pad marker still owed
  logic        lenpend_r, lenpend_nxt; // length bytes still to go in
  logic        wr_en;
  logic [5:0]  wr_addr;
  logic [7:0]  wr_data;
  // pad_wrap: marker landed beyond slot 55, so length goes in a second block
  logic        pad_wrap_r;
  // message word for the current round, registered from the next round index
  logic [31:0] m_r;

  // round datapath
  logic [1:0]  ph;
  logic [31:0] f, t, rot;
  logic [4:0]  sh;

  function automatic logic [3:0] msg_index(input logic [5:0] r);
    logic [3:0] idx;
    case (r[5:4])
      2'd0: idx = r[3:0];
      2'd1: idx = 4'(5 * r + 1);
      2'd2: idx = 4'(3 * r + 5);
      default: idx = 4'(7 * r);
    endcase
    return idx;
  endfunction

  always_comb begin
    ph = rnd_r[5:4];
    case (ph)
      2'd0: f = (b_r & c_r) | (~b_r & d_r);
      2'd1: f = (b_r & d_r) | (c_r & ~d_r);
      2'd2: f = b_r ^ c_r ^ d_r;
      default: f = c_r ^ (b_r | ~d_r);
    endcase
    t = a_r + f + m_r + round_k(rnd_r);
    sh = round_s({ph, rnd_r[1:0]});
    rot = (t << sh) | (t >> (6'd32 - {1'b0, sh}));
  end

  always_comb begin
    state_nxt = state_r; fill_nxt = fill_r; bits_nxt = bits_r; rnd_nxt = rnd_r;
    final_nxt = final_r; lenpend_nxt = lenpend_r;
    wr_en = 1'b0; wr_addr = fill_r; wr_data = in_ch.data.msg_byte;
    unique case (state_r)
      ST_IDLE: if (in_ch.valid) begin
        if (in_ch.data.byte_valid) begin
          wr_en = 1'b1;
          fill_nxt = fill_r + 6'd1;
          bits_nxt = bits_r + 64'd8;
        end
        final_nxt = in_ch.data.last_byte;
        lenpend_nxt = in_ch.data.last_byte;
        if (in_ch.data.byte_valid && fill_r == 6'd63) begin
          state_nxt = ST_ROUND; rnd_nxt = '0;
        end else if (in_ch.data.last_byte) begin
          state_nxt = ST_PAD;
          // 0x80 goes in at the next pad cycle
          wr_en = in_ch.data.byte_valid;
        end
      end
      ST_PAD: begin
        // fill_r here is the slot for the pad marker, zeros or length bytes;
        // final_r shows whether the marker is still owed
        wr_en = 1'b1;
        fill_nxt = fill_r + 6'd1;
        if (final_r) begin
          wr_data = PAD_BYTE; final_nxt = 1'b0;
        end else if (fill_r >= 6'd56 && lenpend_r && !pad_wrap_r) begin
          wr_data = bits_r[8*(fill_r[2:0]) +: 8];
        end else begin
          wr_data = 8'h00;
        end
        if (fill_r == 6'd63) begin
          state_nxt = ST_ROUND; rnd_nxt = '0;
        end
      end
      ST_ROUND: begin
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == 6'd63) state_nxt = ST_ADD;
      end
      ST_ADD: begin
        // marker still owed or length wrapped: pad a fresh block; else idle or output
        if (!lenpend_r) state_nxt = ST_IDLE;
        else if (pad_wrap_r || final_r) state_nxt = ST_PAD;
        else state_nxt = ST_OUT0;
      end
      ST_OUT0: if (out_ch.ready) state_nxt = ST_OUT1;
      ST_OUT1: if (out_ch.ready) begin
        state_nxt = ST_IDLE;
        fill_nxt = '0; bits_nxt = '0; lenpend_nxt = 1'b0;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_ch.ready = (state_r == ST_IDLE);
  assign out_ch.valid = (state_r == ST_OUT0) || (state_r == ST_OUT1);
  assign out_ch.data.digest_word = (state_r == ST_OUT1) ?
      {bswap(h_r[2]), bswap(h_r[3])} : {bswap(h_r[0]), bswap(h_r[1])};
  assign out_ch.data.part_index = (state_r == ST_OUT1);
  assign out_ch.data.last_part = (state_r == ST_OUT1);

  always_ff @(posedge clk) begin
    if (wr_en) store_r[wr_addr[5:2]][8*wr_addr[1:0] +: 8] <= wr_data;
    m_r <= store_r[msg_index(rnd_nxt)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; fill_r <= '0; bits_r <= '0; rnd_r <= '0;
      final_r <= 1'b0; lenpend_r <= 1'b0; pad_wrap_r <= 1'b0;
      h_r[0] <= IV_A; h_r[1] <= IV_B; h_r[2] <= IV_C; h_r[3] <= IV_D;
    end else begin
      state_r <= state_nxt; fill_r <= fill_nxt; bits_r <= bits_nxt;
      rnd_r <= rnd_nxt; final_r <= final_nxt; lenpend_r <= lenpend_nxt;
      if (state_r == ST_PAD && final_r) pad_wrap_r <= (fill_r > 6'd55);
      if (state_nxt == ST_ROUND && state_r != ST_ROUND) begin
        a_r <= h_r[0]; b_r <= h_r[1]; c_r <= h_r[2]; d_r <= h_r[3];
      end
      if (state_r == ST_ROUND) begin
        a_r <= d_r; d_r <= c_r; c_r <= b_r; b_r <= rot + b_r;
      end
      if (state_r == ST_ADD) begin
        h_r[0] <= h_r[0] + a_r; h_r[1] <= h_r[1] + b_r;
        h_r[2] <= h_r[2] + c_r; h_r[3] <= h_r[3] + d_r;
        if (pad_wrap_r && lenpend_r) pad_wrap_r <= 1'b0;
      end
      if (state_r == ST_OUT1 && out_ch.ready) begin
        h_r[0] <= IV_A; h_r[1] <= IV_B; h_r[2] <= IV_C; h_r[3] <= IV_D;
        pad_wrap_r <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire
